// File: hdl/sdcug_pkg.sv
// Shared types and constants for the sensor duty-cycle / upload gate.
// No dependencies.
package sdcug_pkg;

    localparam int unsigned REG_W   = 27;   // width of the millisecond registers
    localparam int unsigned CLK_W   = 32;   // wrapping millisecond clock
    localparam int unsigned ADV_W   = 10;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned CFG_A_W = 3;

    // Register map
    typedef enum logic [CFG_A_W-1:0] {
        REG_WAKE_MS      = 3'd0,
        REG_SLEEP_MS     = 3'd1,
        REG_SETTLE_MS    = 3'd2,
        REG_SEND_GAP_MS  = 3'd3,
        REG_ICON_HOLD_MS = 3'd4,
        REG_INIT_MODE    = 3'd5,
        REG_INIT_MUTED   = 3'd6
    } sdcug_reg_t;

    localparam logic [REG_W-1:0] WAKE_MS_RST      = 27'd30000;
    localparam logic [REG_W-1:0] SLEEP_MS_RST     = 27'd270000;
    localparam logic [REG_W-1:0] SETTLE_MS_RST    = 27'd20000;
    localparam logic [REG_W-1:0] SEND_GAP_MS_RST  = 27'd60000;
    localparam logic [REG_W-1:0] ICON_HOLD_MS_RST = 27'd2000;

    // ms -> s: drop 3 low bits (divide by 8), then divide by 125 through a
    // reciprocal: q = (x * ceil(2^31/125)) >> 31, exact for x < 2^24.
    localparam int unsigned     DIV_IN_W  = REG_W - 3;        // 24
    localparam int unsigned     DIV_MUL_W = 25;
    localparam int unsigned     DIV_SHIFT = 31;
    localparam int unsigned     DIV_PROD_W = DIV_IN_W + DIV_MUL_W;
    localparam int unsigned     DIV_Q_W   = DIV_PROD_W - DIV_SHIFT;  // 18
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 25'd17179870;
    localparam logic [CNT_W-1:0] COUNT_MAX = 17'd131071;

    // Per-item status flags carried down the result pipeline
    typedef struct packed {
        logic mode_now;
        logic muted;
        logic sensor_awake;
        logic wake_cmd;
        logic sleep_cmd;
        logic send_now;
        logic data_fresh;
        logic show_icon;
    } sdcug_flags_t;

endpackage

// File: hdl/sensor_duty_cycle_upload_gate.sv
// Sensor duty-cycle and upload gate, top level. Uses sdcug_pkg, sdcug_sec_div.
// Pipeline: each accepted item passes the input register, then the state/compare
// stage into the middle register, then the seconds-divide stage into the result
// register. One item per cycle while the output is not stalled; all loop state
// updates in the single compare stage. Stalls propagate back through the stages.
// Reset (aresetn, sync, active low): clock and timestamps 0, sensor awake,
// fresh/mode/mute flips cleared, config registers at their defaults.
module sensor_duty_cycle_upload_gate
    import sdcug_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    // config write port
    input  logic               cfg_wr_en,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]   cfg_wr_data,

    // input item
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ADV_W-1:0]   s_advance_ms,
    input  logic               s_short_press,
    input  logic               s_long_press,
    input  logic               s_reading_ok,
    input  logic               s_link_up,

    // result item
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_mode_now,
    output logic               m_muted,
    output logic               m_sensor_awake,
    output logic               m_wake_cmd,
    output logic               m_sleep_cmd,
    output logic               m_send_now,
    output logic               m_data_fresh,
    output logic               m_show_icon,
    output logic [CNT_W-1:0]   m_countdown_s
);

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] wake_ms_reg, sleep_ms_reg, settle_ms_reg;
    logic [REG_W-1:0] send_gap_ms_reg, icon_hold_ms_reg;
    logic             init_mode_reg, init_muted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wake_ms_reg      <= WAKE_MS_RST;
            sleep_ms_reg     <= SLEEP_MS_RST;
            settle_ms_reg    <= SETTLE_MS_RST;
            send_gap_ms_reg  <= SEND_GAP_MS_RST;
            icon_hold_ms_reg <= ICON_HOLD_MS_RST;
            init_mode_reg    <= 1'b0;
            init_muted_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WAKE_MS:      wake_ms_reg      <= cfg_wr_data;
                REG_SLEEP_MS:     sleep_ms_reg     <= cfg_wr_data;
                REG_SETTLE_MS:    settle_ms_reg    <= cfg_wr_data;
                REG_SEND_GAP_MS:  send_gap_ms_reg  <= cfg_wr_data;
                REG_ICON_HOLD_MS: icon_hold_ms_reg <= cfg_wr_data;
                REG_INIT_MODE:    init_mode_reg    <= cfg_wr_data[0];
                REG_INIT_MUTED:   init_muted_reg   <= cfg_wr_data[0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    // Stage 0: input register. Stage 1: flags + ms left. Stage 2: result reg.
    logic in_valid_reg, mid_valid_reg, out_valid_reg;
    logic adv0, adv1, adv2;

    assign adv2    = !out_valid_reg || m_ready;
    assign adv1    = !mid_valid_reg || adv2;
    assign adv0    = !in_valid_reg  || adv1;
    assign s_ready = adv0;

    // item fires through the state stage this cycle
    logic fire1;
    assign fire1 = in_valid_reg && adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv0) in_valid_reg  <= s_valid;
            if (adv1) mid_valid_reg <= in_valid_reg;
            if (adv2) out_valid_reg <= mid_valid_reg;
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [ADV_W-1:0] adv_ms_reg;
    logic             short_reg, long_reg, rd_ok_reg, link_reg;

    always_ff @(posedge aclk) begin
        if (adv0 && s_valid) begin
            adv_ms_reg <= s_advance_ms;
            short_reg  <= s_short_press;
            long_reg   <= s_long_press;
            rd_ok_reg  <= s_reading_ok;
            link_reg   <= s_link_up;
        end
    end

    // ---------------- loop state ----------------
    logic [CLK_W-1:0] clock_ms_reg, phase_start_reg, last_send_reg, icon_start_reg;
    logic             awake_reg, fresh_reg, mode_flip_reg, mute_flip_reg;

    logic [CLK_W-1:0] clock_ms_next, phase_start_next, last_send_next, icon_start_next;
    logic             awake_next, fresh_next, mode_flip_next, mute_flip_next;

    logic [CLK_W-1:0] elapsed, el_left, since_icon, since_send;
    logic [CLK_W-1:0] limit;
    logic [REG_W-1:0] left_ms;
    logic             mode;
    sdcug_flags_t     flags;

    always_comb begin
        clock_ms_next    = clock_ms_reg + CLK_W'(adv_ms_reg);
        phase_start_next = phase_start_reg;
        last_send_next   = last_send_reg;
        icon_start_next  = icon_start_reg;
        awake_next       = awake_reg;
        fresh_next       = fresh_reg;
        mode_flip_next   = mode_flip_reg ^ short_reg;
        mute_flip_next   = mute_flip_reg ^ long_reg;
        flags            = '0;

        // short press restarts the wake period whatever the new mode
        if (short_reg) begin
            awake_next       = 1'b1;
            phase_start_next = clock_ms_next;
            fresh_next       = 1'b0;
            flags.wake_cmd   = 1'b1;
        end

        mode    = init_mode_reg ^ mode_flip_next;
        elapsed = clock_ms_next - phase_start_next;

        if (!mode) begin
            // active: any good frame counts
            if (rd_ok_reg) fresh_next = 1'b1;
        end else if (awake_next) begin
            if (rd_ok_reg && (elapsed > CLK_W'(settle_ms_reg))) fresh_next = 1'b1;
            // wake period over: sleep (may coincide with a short-press wake)
            if (elapsed >= CLK_W'(wake_ms_reg)) begin
                flags.sleep_cmd  = 1'b1;
                awake_next       = 1'b0;
                phase_start_next = clock_ms_next;
                fresh_next       = 1'b0;
            end
        end else begin
            if (elapsed >= CLK_W'(sleep_ms_reg)) begin
                flags.wake_cmd   = 1'b1;
                awake_next       = 1'b1;
                phase_start_next = clock_ms_next;
            end
        end

        // icon test uses the timestamp from before this item's send
        since_icon      = clock_ms_next - icon_start_reg;
        flags.show_icon = since_icon < CLK_W'(icon_hold_ms_reg);

        // ms left in the current period; limit fits in 27 bits so left does too
        limit   = awake_next ? CLK_W'(wake_ms_reg) : CLK_W'(sleep_ms_reg);
        el_left = clock_ms_next - phase_start_next;
        if (mode && (el_left <= limit)) begin
            left_ms = REG_W'(limit - el_left);
        end else begin
            left_ms = '0;
        end

        // upload gate: strict greater-than on the send gap
        since_send = clock_ms_next - last_send_reg;
        if (link_reg && fresh_next && (since_send > CLK_W'(send_gap_ms_reg))) begin
            flags.send_now  = 1'b1;
            last_send_next  = clock_ms_next;
            icon_start_next = clock_ms_next;
            fresh_next      = 1'b0;
        end

        flags.mode_now     = mode;
        flags.muted        = init_muted_reg ^ mute_flip_next;
        flags.sensor_awake = awake_next;
        flags.data_fresh   = fresh_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_ms_reg    <= '0;
            phase_start_reg <= '0;
            last_send_reg   <= '0;
            icon_start_reg  <= '0;
            awake_reg       <= 1'b1;
            fresh_reg       <= 1'b0;
            mode_flip_reg   <= 1'b0;
            mute_flip_reg   <= 1'b0;
        end else if (fire1) begin
            clock_ms_reg    <= clock_ms_next;
            phase_start_reg <= phase_start_next;
            last_send_reg   <= last_send_next;
            icon_start_reg  <= icon_start_next;
            awake_reg       <= awake_next;
            fresh_reg       <= fresh_next;
            mode_flip_reg   <= mode_flip_next;
            mute_flip_reg   <= mute_flip_next;
        end
    end

    // ---------------- stage 1 register ----------------
    sdcug_flags_t     mid_flags_reg;
    logic [REG_W-1:0] mid_left_reg;

    always_ff @(posedge aclk) begin
        if (fire1) begin
            mid_flags_reg <= flags;
            mid_left_reg  <= left_ms;
        end
    end

    // ---------------- stage 2: seconds divide, result register ----------------
    logic [CNT_W-1:0] count_s;

    sdcug_sec_div u_sec_div (
        .left_ms (mid_left_reg),
        .count_s (count_s)
    );

    sdcug_flags_t     out_flags_reg;
    logic [CNT_W-1:0] out_count_reg;

    always_ff @(posedge aclk) begin
        if (adv2 && mid_valid_reg) begin
            out_flags_reg <= mid_flags_reg;
            out_count_reg <= count_s;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_mode_now     = out_flags_reg.mode_now;
    assign m_muted        = out_flags_reg.muted;
    assign m_sensor_awake = out_flags_reg.sensor_awake;
    assign m_wake_cmd     = out_flags_reg.wake_cmd;
    assign m_sleep_cmd    = out_flags_reg.sleep_cmd;
    assign m_send_now     = out_flags_reg.send_now;
    assign m_data_fresh   = out_flags_reg.data_fresh;
    assign m_show_icon    = out_flags_reg.show_icon;
    assign m_countdown_s  = out_count_reg;

endmodule

// File: hdl/sdcug_sec_div.sv
// Milliseconds-left to whole seconds, saturated to the countdown width.
// Depends on sdcug_pkg.
module sdcug_sec_div
    import sdcug_pkg::*;
(
    input  logic [REG_W-1:0] left_ms,
    output logic [CNT_W-1:0] count_s
);

    logic [DIV_IN_W-1:0]   x8;
    logic [DIV_PROD_W-1:0] prod;
    logic [DIV_Q_W-1:0]    quot;

    assign x8   = left_ms[REG_W-1:3];
    assign prod = DIV_PROD_W'(x8) * DIV_PROD_W'(DIV_MUL);
    assign quot = prod[DIV_PROD_W-1:DIV_SHIFT];

    always_comb begin
        if (quot > DIV_Q_W'(COUNT_MAX)) begin
            count_s = COUNT_MAX;
        end else begin
            count_s = quot[CNT_W-1:0];
        end
    end

endmodule
